### sv/ihas_pkg.sv
package ihas_pkg;

  localparam int LEN_BITS = 16;
  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

  localparam logic [3:0] V_PASS      = 4'd0;
  localparam logic [3:0] V_SHORT4    = 4'd1;
  localparam logic [3:0] V_BAD_IHL   = 4'd2;
  localparam logic [3:0] V_FRAG      = 4'd3;
  localparam logic [3:0] V_TRUNC     = 4'd4;
  localparam logic [3:0] V_BOGON4    = 4'd5;
  localparam logic [3:0] V_EXT_DOS   = 4'd6;
  localparam logic [3:0] V_BOGON6    = 4'd7;
  localparam logic [3:0] V_UDP_PORT0 = 4'd8;
  localparam logic [3:0] V_NULL      = 4'd9;
  localparam logic [3:0] V_XMAS      = 4'd10;
  localparam logic [3:0] V_SYNFIN    = 4'd11;
  localparam logic [3:0] V_DROP      = 4'd12;

  localparam logic [7:0] P_ICMP  = 8'd1;
  localparam logic [7:0] P_TCP   = 8'd6;
  localparam logic [7:0] P_UDP   = 8'd17;
  localparam logic [7:0] P_ICMP6 = 8'd58;
  localparam logic [7:0] P_AH    = 8'd51;

  localparam logic [2:0] LIMIT_RESET = 3'd4;

  // Per-packet parse state, kept by the parser and summarised at the last byte.
  typedef struct packed {
    logic [LEN_BITS-1:0] byte_index;
    logic [3:0]          version;
    logic [3:0]          hdr_words;
    logic                frag;
    logic [15:0]         total_len;
    logic                src_lb;
    logic                dst_lb;
    logic [7:0]          proto;
    logic [15:0]         next_off;
    logic [3:0]          ext_walked;
    logic [15:0]         l4_off;
    logic [31:0]         ports;
    logic [5:0]          flags;
    logic                ext_dos;
    logic [7:0]          first_next;
    logic [7:0]          pend_next;
    logic                walk;
    logic                l4_ready;
  } parse_st_t;

  typedef struct packed {
    logic [3:0]  verdict;
    logic [3:0]  ip_version;
    logic [7:0]  l4_protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [5:0]  tcp_flag_bits;
    logic [15:0] payload_offset;
    logic [15:0] packet_length;
  } result_t;

  function automatic logic is_ext(input logic [7:0] p);
    return (p == 8'd0) || (p == 8'd60) || (p == 8'd43) || (p == 8'd44) ||
           (p == 8'd51) || (p == 8'd50) || (p == 8'd135);
  endfunction

  function automatic logic is_l4(input logic [7:0] p);
    return (p == P_TCP) || (p == P_UDP) || (p == P_ICMP) || (p == P_ICMP6);
  endfunction

endpackage

### sv/ihas_parser.sv
module ihas_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic                last,
  input  logic [7:0]          pkt_byte,
  input  logic [2:0]          limit,
  output ihas_pkg::parse_st_t st_nxt_o
);
  import ihas_pkg::*;

  parse_st_t st_r, s;
  logic [15:0] p, r, size;
  logic        skip_l4;

  // Apply the walk decision once proto names the header at next_off.
  function automatic parse_st_t decide(input parse_st_t a, input logic [2:0] lim);
    parse_st_t o;
    o = a;
    if (is_ext(a.proto)) begin
      o.ext_walked = a.ext_walked + 4'd1;
      if (o.ext_walked > {1'b0, lim}) begin
        o.ext_dos = 1'b1;
        o.walk    = 1'b0;
      end else begin
        o.walk = 1'b1;
      end
    end else begin
      o.walk = 1'b0;
      if (is_l4(a.proto)) begin
        o.l4_off   = a.next_off;
        o.l4_ready = 1'b1;
      end else begin
        o.proto  = a.first_next;
        o.l4_off = 16'd40;
      end
    end
    return o;
  endfunction

  always_comb begin
    s       = st_r;
    p       = 16'(st_r.byte_index);
    skip_l4 = 1'b0;
    size    = 16'd0;
    r       = 16'd0;
    if (st_r.byte_index < LEN_MAX) begin
      if (p == 16'd0) begin
        s.version   = pkt_byte[7:4];
        s.hdr_words = pkt_byte[3:0];
        if (pkt_byte[7:4] == 4'd4) s.l4_off = {10'd0, pkt_byte[3:0], 2'b00};
      end
      if (s.version == 4'd4) begin
        if (p == 16'd2) s.total_len = {pkt_byte, 8'd0};
        if (p == 16'd3) s.total_len[7:0] = pkt_byte;
        if (p == 16'd6) s.frag = (pkt_byte[5:0] != 6'd0);
        if (p == 16'd7 && pkt_byte != 8'd0) s.frag = 1'b1;
        if (p == 16'd9) begin
          s.proto    = pkt_byte;
          s.l4_ready = is_l4(pkt_byte);
        end
        if (p == 16'd12) s.src_lb = (pkt_byte == 8'h7F);
        if (p == 16'd16) s.dst_lb = (pkt_byte == 8'h7F);
      end else if (s.version == 4'd6) begin
        if (p == 16'd6) begin
          s.first_next = pkt_byte;
          s.proto      = pkt_byte;
          s.next_off   = 16'd40;
          s            = decide(s, limit);
        end
        if (p == 16'd8) s.src_lb = (pkt_byte == 8'd0);
        else if (p > 16'd8 && p < 16'd23) s.src_lb = s.src_lb && (pkt_byte == 8'd0);
        else if (p == 16'd23) s.src_lb = s.src_lb && (pkt_byte == 8'd1);
        if (p == 16'd24) s.dst_lb = (pkt_byte == 8'd0);
        else if (p > 16'd24 && p < 16'd39) s.dst_lb = s.dst_lb && (pkt_byte == 8'd0);
        else if (p == 16'd39) s.dst_lb = s.dst_lb && (pkt_byte == 8'd1);
        if (s.walk && p >= 16'd40) begin
          if (p == s.next_off) begin
            s.pend_next = pkt_byte;
          end else if (17'(p) == 17'(s.next_off) + 17'd1) begin
            if (s.proto == P_AH) size = {6'd0, 8'(pkt_byte) + 8'd0, 2'b00} + 16'd8;
            else size = {5'd0, pkt_byte, 3'b000} + 16'd8;
            s.next_off = s.next_off + size;
            s.proto    = s.pend_next;
            s          = decide(s, limit);
            skip_l4    = 1'b1;
          end
        end
      end
      if (!skip_l4 && s.l4_ready && p >= s.l4_off) begin
        r = p - s.l4_off;
        if (s.proto == P_ICMP || s.proto == P_ICMP6) begin
          if (r == 16'd4) begin
            s.ports[31:24] = pkt_byte;
            s.ports[15:8]  = pkt_byte;
          end
          if (r == 16'd5) begin
            s.ports[23:16] = pkt_byte;
            s.ports[7:0]   = pkt_byte;
          end
        end else begin
          case (r)
            16'd0:   s.ports[31:24] = pkt_byte;
            16'd1:   s.ports[23:16] = pkt_byte;
            16'd2:   s.ports[15:8]  = pkt_byte;
            16'd3:   s.ports[7:0]   = pkt_byte;
            default: ;
          endcase
          if (r == 16'd13 && s.proto == P_TCP) s.flags = pkt_byte[5:0];
        end
      end
      s.byte_index = st_r.byte_index + LEN_BITS'(1);
    end
  end

  assign st_nxt_o = s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (take) begin
      st_r <= last ? '0 : s;
    end
  end

endmodule

### sv/ihas_verdict.sv
module ihas_verdict (
  input  ihas_pkg::parse_st_t st,
  output ihas_pkg::result_t   res
);
  import ihas_pkg::*;

  logic [15:0] len;
  logic [16:0] need_end;
  logic        l3_ok, l4_done;
  logic [3:0]  v;

  always_comb begin
    len     = 16'(st.byte_index);
    v       = V_PASS;
    l3_ok   = 1'b0;
    l4_done = 1'b0;
    need_end = 17'(st.l4_off) + ((st.proto == P_TCP) ? 17'd20 : 17'd8);
    if (st.version == 4'd4) begin
      if (len < 16'd20) v = V_SHORT4;
      else if (st.hdr_words < 4'd5) v = V_BAD_IHL;
      else if (st.frag) v = V_FRAG;
      else if (len < st.total_len) v = V_TRUNC;
      else if (st.src_lb && !st.dst_lb) v = V_BOGON4;
      else l3_ok = 1'b1;
    end else if (st.version == 4'd6) begin
      if (len < 16'd40) v = V_DROP;
      else if (st.next_off > len) v = V_DROP;
      else if (st.ext_dos) v = V_EXT_DOS;
      else if (st.walk) v = V_DROP;
      else if (st.src_lb && !st.dst_lb) v = V_BOGON6;
      else l3_ok = 1'b1;
    end else begin
      v = V_DROP;
    end
    if (l3_ok && st.l4_ready) begin
      if (17'(len) < need_end) begin
        v = V_DROP;
      end else begin
        l4_done = 1'b1;
        if (st.proto == P_UDP) begin
          if (st.ports[31:16] == 16'd0) v = V_UDP_PORT0;
        end else if (st.proto == P_TCP) begin
          if (st.flags == 6'd0) v = V_NULL;
          else if ((st.flags & 6'h29) == 6'h29) v = V_XMAS;
          else if ((st.flags & 6'h03) == 6'h03) v = V_SYNFIN;
        end
      end
    end
    res.verdict        = v;
    res.ip_version     = st.version;
    res.l4_protocol    = l3_ok ? st.proto : 8'd0;
    res.src_port       = l4_done ? st.ports[31:16] : 16'd0;
    res.dst_port       = l4_done ? st.ports[15:0] : 16'd0;
    res.tcp_flag_bits  = (l4_done && st.proto == P_TCP) ? st.flags : 6'd0;
    res.payload_offset = l3_ok ? st.l4_off : 16'd0;
    res.packet_length  = len;
  end

endmodule

### sv/ip_header_anomaly_screen_unit.sv
// The verdict is registered into the output register at the transfer of the
// last byte of a packet.
// Throughput: one byte per cycle, set by the single-pass byte parser, but a last
// byte stalls while an earlier verdict waits unread; the output register lets a non-last byte be taken meanwhile.
// Reset (rst_n, synchronous): parse state cleared, limit set to 4, no result.
module ip_header_anomaly_screen_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_ext_header_limit,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_pkt_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_verdict,
  output logic [3:0]  out_ip_version,
  output logic [7:0]  out_l4_protocol,
  output logic [15:0] out_src_port,
  output logic [15:0] out_dst_port,
  output logic [5:0]  out_tcp_flag_bits,
  output logic [15:0] out_payload_offset,
  output logic [15:0] out_packet_length
);
  import ihas_pkg::*;

  logic [2:0] limit_r;
  logic       take;
  parse_st_t  st_nxt;
  result_t    res, res_r;
  logic       out_valid_r;

  // A byte that is not last never blocks; a last byte waits for a free slot.
  assign in_ready = !in_last_byte || !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;

  ihas_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .last     (in_last_byte),
    .pkt_byte (in_pkt_byte),
    .limit    (limit_r),
    .st_nxt_o (st_nxt)
  );

  ihas_verdict u_verdict (
    .st  (st_nxt),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) limit_r <= cfg_ext_header_limit;
      if (take && in_last_byte) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_last_byte) res_r <= res;
  end

  assign out_valid          = out_valid_r;
  assign out_verdict        = res_r.verdict;
  assign out_ip_version     = res_r.ip_version;
  assign out_l4_protocol    = res_r.l4_protocol;
  assign out_src_port       = res_r.src_port;
  assign out_dst_port       = res_r.dst_port;
  assign out_tcp_flag_bits  = res_r.tcp_flag_bits;
  assign out_payload_offset = res_r.payload_offset;
  assign out_packet_length  = res_r.packet_length;

endmodule

### tb/ip_header_anomaly_screen_unit_test.sv
`timescale 1ns / 1ps

module ip_header_anomaly_screen_unit_test;
  import ihas_pkg::*;

  localparam int STALL_LIMIT = 20000;

  // Per-packet parse state of the screen.
  typedef struct {
    int unsigned idx;
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic        frag;
    logic [15:0] tot_len;
    logic        src_lb;
    logic        dst_lb;
    logic [7:0]  proto;
    int unsigned next_off;
    logic [3:0]  walked;
    int unsigned l4_off;
    logic [31:0] ports;
    logic [5:0]  flags;
    logic        dos;
    logic [7:0]  first_nh;
    logic [7:0]  pend_nh;
    logic        walking;
    logic        l4_rdy;
  } screen_st_t;

  class verdict_board;
    result_t     pending[$];
    screen_st_t  st;
    logic [2:0]  limit;
    int          errors;

    function new();
      limit = LIMIT_RESET;
      errors = 0;
      clear();
    endfunction

    function void clear();
      st = '{default: 0};
    endfunction

    function bit ext_hdr(logic [7:0] p);
      return p == 0 || p == 60 || p == 43 || p == 44 || p == 51 || p == 50 || p == 135;
    endfunction

    function bit l4_hdr(logic [7:0] p);
      return p == P_TCP || p == P_UDP || p == P_ICMP || p == P_ICMP6;
    endfunction

    function void next_hdr();
      if (ext_hdr(st.proto)) begin
        st.walked = st.walked + 4'd1;
        if (st.walked > {1'b0, limit}) begin
          st.dos = 1;
          st.walking = 0;
        end else begin
          st.walking = 1;
        end
      end else begin
        st.walking = 0;
        if (l4_hdr(st.proto)) begin
          st.l4_off = st.next_off;
          st.l4_rdy = 1;
        end else begin
          st.proto = st.first_nh;
          st.l4_off = 40;
        end
      end
    endfunction

    function void parse(int unsigned p, logic [7:0] b);
      int unsigned r, sz;
      if (p == 0) begin
        st.ver = b[7:4];
        st.ihl = b[3:0];
        if (st.ver == 4) st.l4_off = st.ihl * 4;
      end
      if (st.ver == 4) begin
        if (p == 2) st.tot_len[15:8] = b;
        if (p == 3) st.tot_len[7:0] = b;
        if (p == 6) st.frag = b[5:0] != 0;
        if (p == 7 && b != 0) st.frag = 1;
        if (p == 9) begin
          st.proto = b;
          st.l4_rdy = l4_hdr(b);
        end
        if (p == 12) st.src_lb = b == 8'h7f;
        if (p == 16) st.dst_lb = b == 8'h7f;
      end else if (st.ver == 6) begin
        if (p == 6) begin
          st.first_nh = b;
          st.proto = b;
          st.next_off = 40;
          next_hdr();
        end
        if (p == 8) st.src_lb = b == 0;
        else if (p > 8 && p < 23) st.src_lb = st.src_lb && b == 0;
        else if (p == 23) st.src_lb = st.src_lb && b == 1;
        if (p == 24) st.dst_lb = b == 0;
        else if (p > 24 && p < 39) st.dst_lb = st.dst_lb && b == 0;
        else if (p == 39) st.dst_lb = st.dst_lb && b == 1;
        if (st.walking && p >= 40) begin
          if (p == st.next_off) begin
            st.pend_nh = b;
          end else if (p == st.next_off + 1) begin
            sz = (st.proto == P_AH) ? (b + 2) * 4 : (b + 1) * 8;
            st.next_off = (st.next_off + sz) & 16'hffff;
            st.proto = st.pend_nh;
            next_hdr();
            return;
          end
        end
      end
      if (st.l4_rdy && p >= st.l4_off) begin
        r = p - st.l4_off;
        if (st.proto == P_ICMP || st.proto == P_ICMP6) begin
          if (r == 4) begin
            st.ports[31:24] = b;
            st.ports[15:8] = b;
          end
          if (r == 5) begin
            st.ports[23:16] = b;
            st.ports[7:0] = b;
          end
        end else begin
          if (r < 4) st.ports[(3 - r) * 8 +: 8] = b;
          if (r == 13 && st.proto == P_TCP) st.flags = b[5:0];
        end
      end
    endfunction

    // Notes one accepted byte; at the last byte the verdict is queued.
    function void note_byte(logic [7:0] b, logic last);
      result_t     res;
      int unsigned len, need;
      bit          l3_ok, l4_done;
      l3_ok = 0;
      l4_done = 0;
      if (st.idx < LEN_MAX) begin
        parse(st.idx, b);
        st.idx++;
      end
      if (!last) return;
      len = st.idx;
      res = '0;
      res.verdict = V_PASS;
      if (st.ver == 4) begin
        if (len < 20) res.verdict = V_SHORT4;
        else if (st.ihl < 5) res.verdict = V_BAD_IHL;
        else if (st.frag) res.verdict = V_FRAG;
        else if (len < st.tot_len) res.verdict = V_TRUNC;
        else if (st.src_lb && !st.dst_lb) res.verdict = V_BOGON4;
        else l3_ok = 1;
      end else if (st.ver == 6) begin
        if (len < 40) res.verdict = V_DROP;
        else if (st.next_off > len) res.verdict = V_DROP;
        else if (st.dos) res.verdict = V_EXT_DOS;
        else if (st.walking) res.verdict = V_DROP;
        else if (st.src_lb && !st.dst_lb) res.verdict = V_BOGON6;
        else l3_ok = 1;
      end else begin
        res.verdict = V_DROP;
      end
      if (l3_ok && st.l4_rdy) begin
        need = (st.proto == P_TCP) ? 20 : 8;
        if (len < st.l4_off + need) begin
          res.verdict = V_DROP;
        end else begin
          l4_done = 1;
          if (st.proto == P_UDP) begin
            if (st.ports[31:16] == 0) res.verdict = V_UDP_PORT0;
          end else if (st.proto == P_TCP) begin
            if (st.flags == 0) res.verdict = V_NULL;
            else if ((st.flags & 6'h29) == 6'h29) res.verdict = V_XMAS;
            else if ((st.flags & 6'h03) == 6'h03) res.verdict = V_SYNFIN;
          end
        end
      end
      res.ip_version = st.ver;
      res.l4_protocol = l3_ok ? st.proto : 8'd0;
      res.src_port = l4_done ? st.ports[31:16] : 16'd0;
      res.dst_port = l4_done ? st.ports[15:0] : 16'd0;
      res.tcp_flag_bits = (l4_done && st.proto == P_TCP) ? st.flags : 6'd0;
      res.payload_offset = l3_ok ? st.l4_off[15:0] : 16'd0;
      res.packet_length = len[15:0];
      pending.push_back(res);
      clear();
    endfunction

    function void check_verdict(result_t got);
      result_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected verdict %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10) $display("verdict mismatch: expected %p, got %p", exp_r, got);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_ext_header_limit;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_pkt_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  result_t     got;

  verdict_board board;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  quiet_cycles;
  int  accepted_bytes;
  int  sent_pkts;

  ip_header_anomaly_screen_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_ext_header_limit(cfg_ext_header_limit),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_pkt_byte(in_pkt_byte),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_verdict(got.verdict),
    .out_ip_version(got.ip_version),
    .out_l4_protocol(got.l4_protocol),
    .out_src_port(got.src_port),
    .out_dst_port(got.dst_port),
    .out_tcp_flag_bits(got.tcp_flag_bits),
    .out_payload_offset(got.payload_offset),
    .out_packet_length(got.packet_length)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver side: check each result transfer and stall at random.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) board.check_verdict(got);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("ip_header_anomaly_screen_unit verification failed");
      $finish;
    end
  end

  // Valid is dropped only in idle cycles, so back-to-back bytes see one
  // assignment per clock edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_pkt_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_byte(b, last);
    accepted_bytes++;
  endtask

  task automatic send_packet(input logic [7:0] pkt[$]);
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
    sent_pkts++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [2:0] v);
    cfg_we <= 1;
    cfg_ext_header_limit <= v;
    @(posedge clk);
    cfg_we <= 0;
    board.limit = v;
  endtask

  // Layer-4 header with random content; flags chosen to hit the scan cases.
  task automatic add_l4(inout logic [7:0] pkt[$], input logic [7:0] proto);
    int n;
    logic [7:0] b;
    n = (proto == P_TCP) ? 20 : 8;
    if ($urandom_range(9) == 0) n = $urandom_range(n - 1);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom);
      if (i < 2 && $urandom_range(5) == 0) b = 0;
      if (i == 13 && proto == P_TCP) begin
        case ($urandom_range(4))
          0: b = 0;
          1: b = 8'h29 | (8'($urandom) & 8'hc0);
          2: b = 8'h03 | (8'($urandom) & 8'hd0);
          default: b = 8'($urandom);
        endcase
      end
      pkt.push_back(b);
    end
    repeat ($urandom_range(0, 6)) pkt.push_back(8'($urandom));
  endtask

  function automatic logic [7:0] pick_l4();
    case ($urandom_range(5))
      0: return P_ICMP;
      1: return P_ICMP6;
      2: return P_UDP;
      3: return 8'($urandom);
      default: return P_TCP;
    endcase
  endfunction

  function automatic logic [7:0] pick_ext();
    case ($urandom_range(6))
      0: return 8'd0;
      1: return 8'd60;
      2: return 8'd43;
      3: return 8'd44;
      4: return P_AH;
      5: return 8'd50;
      default: return 8'd135;
    endcase
  endfunction

  task automatic make_v4(output logic [7:0] pkt[$]);
    logic [3:0] ihl;
    logic [7:0] proto;
    int total;
    pkt = {};
    ihl = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(5, 7));
    proto = pick_l4();
    pkt.push_back({4'd4, ihl});
    for (int i = 1; i < 20; i++) pkt.push_back(8'($urandom));
    pkt[6] = ($urandom_range(7) == 0) ? 8'($urandom) : (8'($urandom) & 8'hc0);
    pkt[7] = ($urandom_range(7) == 0) ? 8'($urandom) : 8'd0;
    pkt[9] = proto;
    if ($urandom_range(5) == 0) pkt[12] = 8'h7f;
    if ($urandom_range(3) == 0) pkt[16] = 8'h7f;
    for (int i = 20; i < ihl * 4; i++) pkt.push_back(8'($urandom));
    add_l4(pkt, proto);
    total = pkt.size();
    if ($urandom_range(7) == 0) total += $urandom_range(1, 300);
    else total -= $urandom_range(0, total);
    pkt[2] = total[15:8];
    pkt[3] = total[7:0];
    if ($urandom_range(15) == 0) pkt = pkt[0:$urandom_range(19)];
  endtask

  task automatic make_v6(output logic [7:0] pkt[$]);
    int nexts;
    logic [7:0] nh, next;
    logic [7:0] hl;
    int sz;
    pkt = {};
    pkt.push_back(8'h60 | (8'($urandom) & 8'h0f));
    for (int i = 1; i < 40; i++) pkt.push_back(8'($urandom));
    nexts = $urandom_range(0, 8);
    nh = (nexts > 0) ? pick_ext() : pick_l4();
    pkt[6] = nh;
    if ($urandom_range(3) != 0) begin
      for (int i = 8; i < 40; i++) pkt[i] = 0;
      pkt[23] = 8'($urandom_range(1));
      pkt[39] = 8'($urandom_range(1));
    end
    for (int k = 0; k < nexts; k++) begin
      next = (k == nexts - 1) ? pick_l4() : pick_ext();
      hl = 8'($urandom_range(0, 2));
      sz = (nh == P_AH) ? (hl + 2) * 4 : (hl + 1) * 8;
      pkt.push_back(next);
      pkt.push_back(hl);
      for (int i = 2; i < sz; i++) pkt.push_back(8'($urandom));
      nh = next;
    end
    add_l4(pkt, nh);
    if ($urandom_range(15) == 0) pkt = pkt[0:$urandom_range(pkt.size() - 1)];
  endtask

  task automatic random_packets(input int bytes_goal);
    logic [7:0] pkt[$];
    int start;
    start = accepted_bytes;
    while (accepted_bytes - start < bytes_goal) begin
      case ($urandom_range(9))
        0: begin
          pkt = {};
          repeat ($urandom_range(1, 30)) pkt.push_back(8'($urandom));
        end
        1, 2, 3: make_v4(pkt);
        default: make_v6(pkt);
      endcase
      send_packet(pkt);
    end
  endtask

  initial begin
    logic [7:0] pkt[$];
    board = new();
    rst_n = 0;
    cfg_we = 0;
    cfg_ext_header_limit = 0;
    in_valid = 0;
    in_pkt_byte = 0;
    in_last_byte = 0;
    out_ready = 1;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    accepted_bytes = 0;
    sent_pkts = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: single-byte packets 00 and ff (unknown versions), short v4.
    pkt = {8'h00};
    send_packet(pkt);
    pkt = {8'hff};
    send_packet(pkt);
    pkt = {8'h45, 8'h00, 8'h00};
    send_packet(pkt);
    // IPv6 with a chain longer than the default limit, then with the limit at zero and at seven.
    pkt = {};
    pkt.push_back(8'h60);
    for (int i = 1; i < 40; i++) pkt.push_back(8'h00);
    pkt[6] = 8'd0;
    for (int k = 0; k < 6; k++) begin
      pkt.push_back(8'd60);
      pkt.push_back(8'd0);
      repeat (6) pkt.push_back(8'h00);
    end
    send_packet(pkt);
    drain();
    write_limit(3'd0);
    send_packet(pkt);
    drain();
    write_limit(3'd7);
    send_packet(pkt);
    drain();

    // Random phases across idling patterns and limit settings.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? 49 : (ph == 2 ? 0 : 0);
      recv_stall_pct = (ph == 2 || ph == 3) ? 49 : 0;
      if (ph == 3) begin
        send_idle_pct = 9;
        recv_stall_pct = 9;
      end
      write_limit(ph == 0 ? 3'd7 : 3'($urandom));
      random_packets(300);
      drain();
    end
    write_limit(3'd0);
    random_packets(250);
    drain();

    if (board.errors == 0 && board.pending.size() == 0)
      $display("ip_header_anomaly_screen_unit verification clean");
    else
      $display("ip_header_anomaly_screen_unit verification failed");
    $finish;
  end

endmodule

### filelist.f
sv/ihas_pkg.sv
sv/ihas_parser.sv
sv/ihas_verdict.sv
sv/ip_header_anomaly_screen_unit.sv
tb/ip_header_anomaly_screen_unit_test.sv
